// ===== rtl/omfu_pkg.sv =====
// Package for the occupancy marker with upward fill.
// Holds the payload types of the input and result channels.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package omfu_pkg;

    typedef struct packed {
        logic signed [15:0] score;
        logic               last_colour;
    } t_in_item;

    typedef struct packed {
        logic [3:0] cell_column;
        logic [3:0] cell_row;
        logic       occupied;
        logic       any_robot;
        logic       frame_done;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/omfu_stream_if.sv =====
// Valid/ready stream channel with a typed payload.
// Payload type is set per instance; typically an omfu_pkg struct.
`timescale 1ns / 1ps
`default_nettype none

interface omfu_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/occupancy_mark_fill_upwards.sv =====
// Top level of the occupancy marker with upward fill.
// Depends on omfu_pkg (payload types) and omfu_stream_if (channels).
//
// Channel      Dir   Payload                                        Accept
// i_in         in    score[15:0] signed, last_colour                valid && ready
// o_out        out   cell_column, cell_row, occupied, any_robot,    valid && ready
//                    frame_done
// i_cfg_*      in    score_threshold[15:0] signed                   i_cfg_we
//
// One item per cycle while the input is not stalled: the compare and the per-column valid-bit lookup sit
// between the input handshake and the result register.
// A last-score item yields one result, registered in the cycle after acceptance.
// Input stalls only while the result register is full and not taken.
// Synchronous active-low reset clears the column store, counters and flags.
`timescale 1ns / 1ps
`default_nettype none

module occupancy_mark_fill_upwards #(
    parameter int GRID_WIDTH  = 16,
    parameter int GRID_HEIGHT = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire  signed [15:0]  i_cfg_wdata,
    omfu_stream_if.sink         i_in,
    omfu_stream_if.source       o_out
);

    localparam int CW = (GRID_WIDTH  > 1) ? $clog2(GRID_WIDTH)  : 1;
    localparam int RW = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
    localparam logic [CW-1:0] LAST_COL = CW'(GRID_WIDTH - 1);
    localparam logic [RW-1:0] LAST_ROW = RW'(GRID_HEIGHT - 1);

    logic signed [15:0]     r_threshold;
    logic [GRID_WIDTH-1:0]  r_col_valid, n_col_valid;
    logic                   r_cell_hit, n_cell_hit;
    logic [CW-1:0]          r_col, n_col;
    logic [RW-1:0]          r_row, n_row;
    logic                   r_robot_seen, n_robot_seen;
    logic                   r_out_valid, n_out_valid;
    omfu_pkg::t_out_item    r_out, n_out;

    logic                   acc;
    logic                   hit;
    logic                   done;
    logic [31:0]            col_ext;
    logic [31:0]            row_ext;
    omfu_pkg::t_in_item     in_item;

    assign in_item     = i_in.payload;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign acc         = i_in.valid && i_in.ready;
    assign hit         = r_cell_hit || (in_item.score < r_threshold);
    assign done        = (r_col == LAST_COL) && (r_row >= LAST_ROW);
    assign col_ext     = 32'(r_col);
    assign row_ext     = 32'(r_row);

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    always_comb begin
        n_col_valid  = r_col_valid;
        n_cell_hit   = r_cell_hit;
        n_col        = r_col;
        n_row        = r_row;
        n_robot_seen = r_robot_seen;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out        = r_out;
        if (acc) begin
            if (!in_item.last_colour) begin
                n_cell_hit = hit;
            end else begin
                n_out_valid          = 1'b1;
                n_out.cell_column    = col_ext[3:0];
                n_out.cell_row       = row_ext[3:0];
                n_out.occupied       = hit || r_col_valid[r_col];
                n_out.any_robot      = r_robot_seen || hit;
                n_out.frame_done     = done;
                n_cell_hit           = 1'b0;
                if (done) begin
                    n_col_valid  = '0;
                    n_col        = '0;
                    n_row        = '0;
                    n_robot_seen = 1'b0;
                end else begin
                    if (hit) begin
                        n_col_valid[r_col] = 1'b1;
                        n_robot_seen       = 1'b1;
                    end
                    if (r_col == LAST_COL) begin
                        n_col = '0;
                        n_row = r_row + 1'b1;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= '0;
            r_col_valid  <= '0;
            r_cell_hit   <= 1'b0;
            r_col        <= '0;
            r_row        <= '0;
            r_robot_seen <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_threshold <= i_cfg_wdata;
            end
            r_col_valid  <= n_col_valid;
            r_cell_hit   <= n_cell_hit;
            r_col        <= n_col;
            r_row        <= n_row;
            r_robot_seen <= n_robot_seen;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    a_frame_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && in_item.last_colour && done) |=>
            (r_col_valid == '0 && !r_robot_seen && r_col == '0 && r_row == '0))
        else $error("frame state not cleared after last cell");

    a_no_robot_no_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.any_robot) |-> !r_out.occupied)
        else $error("occupied reported with no robot cell seen");

    a_store_implies_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col_valid != '0) |-> r_robot_seen)
        else $error("column marked without robot_seen");

    a_partial_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !in_item.last_colour && !r_out_valid) |=> !r_out_valid)
        else $error("result produced for a non-last score");

endmodule

`default_nettype wire

// ===== bench/occupancy_mark_fill_upwards_tb.sv =====
// Testbench for occupancy_mark_fill_upwards: random scores stream through a bursty driver,
// and a monitor checks each cell result against a built-in model of the marker and upward fill.
// Depends on omfu_pkg and omfu_stream_if.
`timescale 1ns / 1ps

module occupancy_mark_fill_upwards_tb;

    localparam int GRID_W      = 16;
    localparam int GRID_H      = 16;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int NUM_PHASES  = 7;

    typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_SPARSE} t_ready_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic signed [15:0] i_cfg_wdata;

    omfu_stream_if #(.t_payload(omfu_pkg::t_in_item))  in_ch ();
    omfu_stream_if #(.t_payload(omfu_pkg::t_out_item)) out_ch ();

    occupancy_mark_fill_upwards #(
        .GRID_WIDTH (GRID_W),
        .GRID_HEIGHT(GRID_H)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // occupancy model state
    logic signed [15:0] score_limit;
    logic               column_marked [GRID_W];
    logic               cell_below;
    int                 cur_column;
    int                 cur_row;
    logic               frame_has_robot;

    omfu_pkg::t_in_item  pending_items [$];
    omfu_pkg::t_out_item expected_cells [$];
    int        error_count = 0;
    int        results_seen = 0;

    task automatic clear_frame_state();
        for (int i = 0; i < GRID_W; i++) begin
            column_marked[i] = 1'b0;
        end
        cell_below      = 1'b0;
        cur_column      = 0;
        cur_row         = 0;
        frame_has_robot = 1'b0;
    endtask

    task automatic predict_cell(input omfu_pkg::t_in_item it);
        omfu_pkg::t_out_item res;
        logic      hit;
        logic      done;
        hit = cell_below || (it.score < score_limit);
        if (!it.last_colour) begin
            cell_below = hit;
            return;
        end
        if (hit) begin
            frame_has_robot       = 1'b1;
            column_marked[cur_column] = 1'b1;
        end
        done            = (cur_column == GRID_W - 1) && (cur_row >= GRID_H - 1);
        res.cell_column = cur_column[3:0];
        res.cell_row    = cur_row[3:0];
        res.occupied    = hit || column_marked[cur_column];
        res.any_robot   = frame_has_robot;
        res.frame_done  = done;
        expected_cells.push_back(res);
        cell_below = 1'b0;
        if (done) begin
            clear_frame_state();
        end else if (cur_column == GRID_W - 1) begin
            cur_column = 0;
            cur_row++;
        end else begin
            cur_column++;
        end
    endtask

    // driver: bursts of items with random gaps
    int gap_left   = 0;
    int burst_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_cell(in_ch.payload);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    in_ch.valid   <= 1'b1;
                    in_ch.payload <= pending_items.pop_front();
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 48);
                    end
                    burst_left--;
                    if (burst_left == 0) begin
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: ready pattern, long hold-offs, result checks
    t_ready_mode ready_mode = RDY_ALWAYS;
    int          mode_left  = 0;
    int          hold_left  = 0;
    int          holds_done = 0;
    int          sparse_cnt = 0;

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        omfu_pkg::t_out_item want;
        omfu_pkg::t_out_item got;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.payload;
                results_seen++;
                if (expected_cells.size() == 0) begin
                    $error("unexpected result for column %0d row %0d",
                           got.cell_column, got.cell_row);
                    error_count++;
                end else begin
                    want = expected_cells.pop_front();
                    check_field("cell_column", want.cell_column, got.cell_column);
                    check_field("cell_row", want.cell_row, got.cell_row);
                    check_field("occupied", want.occupied, got.occupied);
                    check_field("any_robot", want.any_robot, got.any_robot);
                    check_field("frame_done", want.frame_done, got.frame_done);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (holds_done < 2 && pending_items.size() > 100 &&
                         results_seen >= 60 + 150 * holds_done) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    ready_mode = t_ready_mode'($urandom_range(0, 2));
                    mode_left  = $urandom_range(10, 80);
                end
                mode_left--;
                sparse_cnt++;
                case (ready_mode)
                    RDY_ALWAYS: out_ch.ready <= 1'b1;
                    RDY_RANDOM: out_ch.ready <= $urandom_range(0, 1);
                    default:    out_ch.ready <= (sparse_cnt % 3 == 0);
                endcase
            end
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic add_item(input logic signed [15:0] s, input logic last);
        omfu_pkg::t_in_item it;
        it.score       = s;
        it.last_colour = last;
        pending_items.push_back(it);
    endtask

    function automatic logic signed [15:0] pick_score(input int robot_pct);
        int sel;
        int lim;
        int v;
        sel = $urandom_range(0, 99);
        lim = score_limit;
        if (sel < 8) begin
            v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
        end else if (sel < 18) begin
            v = $urandom;
        end else if (sel < 24) begin
            v = lim;
        end else if ($urandom_range(0, 99) < robot_pct && lim != -32768) begin
            v = int'($urandom_range(0, lim + 32767)) - 32768;
        end else begin
            v = lim + int'($urandom_range(0, 32767 - lim));
        end
        return v[15:0];
    endfunction

    task automatic add_cell(input int robot_pct, inout int added);
        int n;
        n = ($urandom_range(0, 1) != 0) ? 1 : $urandom_range(2, 4);
        for (int i = 0; i < n; i++) begin
            add_item(pick_score(robot_pct), i == n - 1);
        end
        added += n;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_items.size() != 0 || in_ch.valid || expected_cells.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic signed [15:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        score_limit = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        logic signed [15:0] phase_limit [NUM_PHASES];
        int                 phase_pct [NUM_PHASES];
        int                 added;
        phase_limit = '{16'sh0100, -16'sd32768, 16'sd32767, 16'sh0000,
                        16'sh0000, -16'sh0100, 16'sh0000};
        phase_pct   = '{5, 3, 2, 40, 10, 1, 20};
        phase_limit[3] = $urandom;
        phase_limit[6] = $urandom;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        out_ch.ready   = 1'b0;
        score_limit    = '0;
        clear_frame_state();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset threshold: extremes, equal score, hit early or mid-cell
        add_item(-16'sd32768, 1'b1);
        add_item(16'sd32767, 1'b1);
        add_item(16'sd0, 1'b1);
        add_item(-16'sd1, 1'b1);
        add_item(16'sd5, 1'b0);
        add_item(-16'sd3, 1'b0);
        add_item(16'sd9, 1'b1);
        add_item(16'sd1, 1'b0);
        add_item(16'sd0, 1'b1);
        add_item(-16'sd32768, 1'b0);
        add_item(16'sd32767, 1'b1);
        wait_drained();
        write_threshold(16'sd32767);
        add_item(16'sd32767, 1'b1);
        add_item(16'sd32766, 1'b1);
        wait_drained();
        write_threshold(-16'sd32768);
        add_item(-16'sd32768, 1'b1);
        add_item(16'sd0, 1'b1);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_threshold(phase_limit[p]);
            added = 0;
            while (added < 190) begin
                add_cell(phase_pct[p], added);
            end
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (error_count == 0 && expected_cells.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/omfu_pkg.sv
rtl/omfu_stream_if.sv
rtl/occupancy_mark_fill_upwards.sv
bench/occupancy_mark_fill_upwards_tb.sv
